[hw/rtl/nsdf_pkg.sv]
// ----------------------------------------------------------------------------
// nsdf_pkg
// Shared types and constants for the NSDF pitch-lag engine.
// ----------------------------------------------------------------------------
package nsdf_pkg;

  localparam int SampleW = 16;
  localparam int LagW    = 10;
  localparam int OutW    = 41;
  localparam int QuoW    = 17;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // one queued command
  typedef struct packed {
    logic                      command;
    logic signed [SampleW-1:0] sample;
    logic [LagW-1:0]           lag;
  } item_t;

  // back end status seen by the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

[hw/rtl/nsdf_pitch_lag_engine_top.sv]
// ----------------------------------------------------------------------------
// nsdf_pitch_lag_engine_top
// NSDF pitch-lag engine: sample window, lag query, 2r/m in Q1.15.
// ----------------------------------------------------------------------------
// After reset the window store is cleared, busy_o high.
// Commands transfer when start_i is high and busy_o low into a two-entry
// queue. A load is written to the store when the back end pops it and gives no
// result. A query at lag t below WINDOW goes through the pop, the lag walk
// (one product pair per cycle, set by the two store read ports), the drain,
// the divider and the formatting state; a zero-energy or out-of-range query
// skips the divider. Each result shows for one cycle with done_o high and
// cannot be stalled.
module nsdf_pitch_lag_engine_top #(
  parameter int WINDOW = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                command_i,
  input  logic signed [nsdf_pkg::SampleW-1:0] sample_i,
  input  logic [nsdf_pkg::LagW-1:0]           lag_i,
  output logic                                done_o,
  output logic signed [nsdf_pkg::SampleW-1:0] nsdf_value_o,
  output logic signed [nsdf_pkg::OutW-1:0]    autocorr_o,
  output logic [nsdf_pkg::OutW-1:0]           energy_o,
  output logic                                zero_energy_o
);
  import nsdf_pkg::*;

  item_t      item;
  logic       item_valid;
  back_stat_t stat;

  nsdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .command_i    (command_i),
    .sample_i     (sample_i),
    .lag_i        (lag_i),
    .stat_i       (stat),
    .busy_o       (busy_o),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  nsdf_back #(.WINDOW(WINDOW)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .stat_o        (stat),
    .done_o        (done_o),
    .nsdf_value_o  (nsdf_value_o),
    .autocorr_o    (autocorr_o),
    .energy_o      (energy_o),
    .zero_energy_o (zero_energy_o)
  );

endmodule

[hw/rtl/nsdf_front.sv]
// ----------------------------------------------------------------------------
// nsdf_front
// Accepts commands and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module nsdf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          command_i,
  input  logic signed [nsdf_pkg::SampleW-1:0] sample_i,
  input  logic [nsdf_pkg::LagW-1:0]     lag_i,
  input  nsdf_pkg::back_stat_t          stat_i,
  output logic                          busy_o,
  output logic                          item_valid_o,
  output nsdf_pkg::item_t               item_o
);
  import nsdf_pkg::*;

  item_t       slot_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  // transfer in when not full and not clearing
  assign busy_o       = (cnt_q == 2'd2) || stat_i.clearing;
  assign push         = start_i && !busy_o;
  assign pop          = stat_i.pop;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= '{command: command_i, sample: sample_i, lag: lag_i};
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hw/rtl/nsdf_div.sv]
// ----------------------------------------------------------------------------
// nsdf_div
// Restoring divider, one quotient bit per cycle: (2|r|*2^16 + m) / (2m).
// ----------------------------------------------------------------------------
module nsdf_div #(
  parameter int AccW = 43
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [AccW-1:0]              mag_i,
  input  logic [AccW-1:0]              den_i,
  output logic                         done_o,
  output logic [nsdf_pkg::QuoW-1:0]    quot_o
);
  import nsdf_pkg::*;

  logic [AccW:0]   rem_q, dv_q;
  logic [QuoW-1:0] low_q, quo_q;
  logic [4:0]      cnt_q;
  logic            run_q, done_q;
  logic [AccW+1:0] rem2;
  logic            ge;

  // one trial subtraction per cycle
  assign rem2 = {rem_q, low_q[QuoW-1]};
  assign ge   = (rem2 >= {1'b0, dv_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= (AccW+1)'(mag_i) + (AccW+1)'(den_i >> QuoW);
      dv_q  <= {den_i, 1'b0};
      low_q <= den_i[QuoW-1:0];
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? (AccW+1)'(rem2 - {1'b0, dv_q}) : rem2[AccW:0];
      low_q <= {low_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'(QuoW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[hw/rtl/nsdf_back.sv]
// ----------------------------------------------------------------------------
// nsdf_back
// Window store, lag walk with product and square accumulation, result
// formatting. Clears the store after reset.
// ----------------------------------------------------------------------------
module nsdf_back #(
  parameter int WINDOW = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               item_valid_i,
  input  nsdf_pkg::item_t                    item_i,
  output nsdf_pkg::back_stat_t               stat_o,
  output logic                               done_o,
  output logic signed [nsdf_pkg::SampleW-1:0] nsdf_value_o,
  output logic signed [nsdf_pkg::OutW-1:0]   autocorr_o,
  output logic [nsdf_pkg::OutW-1:0]          energy_o,
  output logic                               zero_energy_o
);
  import nsdf_pkg::*;

  localparam int AW   = $clog2(WINDOW);
  localparam int AccW = AW + 33;
  localparam logic [AW-1:0] LastAddr = AW'(WINDOW - 1);
  localparam logic signed [63:0] RMax = 64'sd1099511627775;
  localparam logic signed [63:0] RMin = -64'sd1099511627776;
  localparam logic [63:0]        MMax = 64'd2199023255551;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_ACC   = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic signed [SampleW-1:0] mem_q [WINDOW];
  logic signed [SampleW-1:0] a_q, b_q;
  logic signed [31:0]        prod_q;
  logic [30:0]               sqa_q, sqb_q;
  logic signed [AccW-1:0]    r_q;
  logic [AccW-1:0]           m_q, mag;
  logic [AW-1:0]             clr_q, wp_q, j_q, last_q, t_q;
  logic                      rd_v_q, mul_v_q;
  logic                      pop, is_load, lag_ok, we;
  logic [AW-1:0]             waddr;
  logic signed [SampleW-1:0] wdata;
  logic                      div_start, div_done;
  logic [QuoW-1:0]           quot;
  logic [QuoW-1:0]           qsat;
  logic signed [63:0]        r64;
  logic [63:0]               m64;
  logic                      done_q;

  assign pop     = (state_q == ST_IDLE) && item_valid_i;
  assign is_load = (item_i.command == CMD_LOAD);
  assign lag_ok  = (32'(item_i.lag) < WINDOW);
  assign stat_o  = '{pop: pop, clearing: (state_q == ST_CLEAR)};

  // store write port: clearing pass or sample load
  assign we    = (state_q == ST_CLEAR) || (pop && is_load);
  assign waddr = (state_q == ST_CLEAR) ? clr_q : wp_q;
  assign wdata = (state_q == ST_CLEAR) ? '0 : item_i.sample;

  // window store, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    a_q <= mem_q[j_q];
    b_q <= mem_q[AW'(j_q + t_q)];
  end

  // product and squares stage, full 32-bit products
  always_ff @(posedge clk_i) begin
    prod_q <= a_q * b_q;
    sqa_q  <= 31'(32'(a_q) * 32'(a_q));
    sqb_q  <= 31'(32'(b_q) * 32'(b_q));
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_CLEAR: if (clr_q == LastAddr) state_d = ST_IDLE;
      ST_IDLE: begin
        if (pop && !is_load) state_d = lag_ok ? ST_ACC : ST_FIN;
      end
      ST_ACC:   if (j_q == last_q) state_d = ST_DRAIN;
      ST_DRAIN: begin
        if (!rd_v_q && !mul_v_q) begin
          if (m_q == '0) begin
            state_d = ST_FIN;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV:   if (div_done) state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      wp_q    <= '0;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == ST_ACC);
      mul_v_q <= rd_v_q;
      done_q  <= (state_q == ST_FIN);
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (pop && is_load) wp_q <= (wp_q == LastAddr) ? '0 : wp_q + AW'(1);
    end
  end

  // lag walk and accumulators
  always_ff @(posedge clk_i) begin
    if (pop && !is_load) begin
      t_q    <= AW'(item_i.lag);
      j_q    <= '0;
      last_q <= AW'(WINDOW - 1 - 32'(item_i.lag));
      r_q    <= '0;
      m_q    <= '0;
    end else begin
      if (state_q == ST_ACC) j_q <= j_q + AW'(1);
      if (mul_v_q) begin
        r_q <= r_q + AccW'(prod_q);
        m_q <= m_q + AccW'(sqa_q) + AccW'(sqb_q);
      end
    end
  end

  assign mag = (r_q < 0) ? AccW'(-r_q) : AccW'(r_q);

  nsdf_div #(.AccW(AccW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (mag),
    .den_i   (m_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // result formatting with saturation
  assign r64  = 64'(r_q);
  assign m64  = 64'(m_q);
  assign qsat = (r_q < 0) ? ((quot > QuoW'(32768)) ? QuoW'(32768) : quot)
                          : ((quot > QuoW'(32767)) ? QuoW'(32767) : quot);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) begin
      zero_energy_o <= (m_q == '0);
      if (m_q == '0)    nsdf_value_o <= '0;
      else if (r_q < 0) nsdf_value_o <= SampleW'(QuoW'(0) - qsat);
      else              nsdf_value_o <= SampleW'(qsat);
      autocorr_o <= (r64 > RMax) ? OutW'(RMax) :
                    (r64 < RMin) ? OutW'(RMin) : OutW'(r64);
      energy_o   <= (m64 > MMax) ? OutW'(MMax) : OutW'(m64);
    end
  end

  assign done_o = done_q;

  // checks
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_zero_nsdf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_energy_o |-> nsdf_value_o == '0 && autocorr_o == '0)
    else $error("zero energy with nonzero result");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> item_valid_i && state_q == ST_IDLE) else $error("pop outside idle");
  a_div_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !mul_v_q && !rd_v_q) else $error("divide before sums done");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NSDF pitch-lag engine. A driver plays queued
// load and query commands with random idle bursts. A monitor compares each
// result strobe against an in-bench window model that predicts r(t), m(t)
// and the rounded, saturated 2r/m.
// ----------------------------------------------------------------------------
module testbench;
  import nsdf_pkg::*;

  localparam int Win = 1024;

  typedef struct packed {
    logic signed [SampleW-1:0] nsdf;
    logic signed [OutW-1:0]    acorr;
    logic [OutW-1:0]           energy;
    logic                      zflag;
  } lag_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      command_i = CMD_LOAD;
  logic signed [SampleW-1:0] sample_i = '0;
  logic [LagW-1:0]           lag_i = '0;
  logic                      busy_o, done_o, zero_energy_o;
  logic signed [SampleW-1:0] nsdf_value_o;
  logic signed [OutW-1:0]    autocorr_o;
  logic [OutW-1:0]           energy_o;

  item_t       cmd_queue[$];
  lag_result_t lag_results[$];
  int          win_model[Win];
  int          wr_pos = 0;
  int          errors = 0;
  int          idle_left = 0;
  bit          fill_done = 1'b0;
  bit          calm = 1'b0;
  logic        took = 1'b0;

  nsdf_pitch_lag_engine_top #(.WINDOW(Win)) i_dut (.*);

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // window model: loads update the store, queries produce one result
  task automatic model_command(input item_t it);
    longint            acc_r;
    longint unsigned   acc_m, mag, quo;
    longint            a, b;
    lag_result_t       res;
    begin
      if (it.command == CMD_LOAD) begin
        win_model[wr_pos] = int'(it.sample);
        wr_pos = (wr_pos + 1) % Win;
      end else begin
        acc_r = 0;
        acc_m = 0;
        for (int j = 0; j < Win - int'(it.lag); j++) begin
          a = win_model[j];
          b = win_model[j + int'(it.lag)];
          acc_r += a * b;
          acc_m += longint'(a * a) + longint'(b * b);
        end
        res.zflag = (acc_m == 0);
        res.nsdf = '0;
        if (acc_m != 0) begin
          mag = (acc_r < 0) ? longint'(-acc_r) : longint'(acc_r);
          quo = ((mag << 17) + acc_m) / (acc_m << 1);
          if (acc_r < 0) begin
            if (quo > 32768) quo = 32768;
            res.nsdf = -quo[15:0];
          end else begin
            if (quo > 32767) quo = 32767;
            res.nsdf = quo[15:0];
          end
        end
        if (acc_r > (longint'(1) << 40) - 1) acc_r = (longint'(1) << 40) - 1;
        if (acc_r < -(longint'(1) << 40)) acc_r = -(longint'(1) << 40);
        if (acc_m > (longint'(1) << 41) - 1) acc_m = (longint'(1) << 41) - 1;
        res.acorr = acc_r[OutW-1:0];
        res.energy = acc_m[OutW-1:0];
        lag_results.push_back(res);
      end
    end
  endtask

  // accepted transfer: feed the model
  always @(posedge clk_i) begin
    took <= rst_ni && start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) begin
      model_command('{command: command_i, sample: sample_i, lag: lag_i});
    end
  end

  // driver: present a new command once the previous one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || took)) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        idle_left <= $urandom_range(0, 18);
        start_i <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        item_t nxt;
        nxt = cmd_queue.pop_front();
        command_i <= nxt.command;
        sample_i <= nxt.sample;
        lag_i <= nxt.lag;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: check each result strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (lag_results.size() == 0) begin
        $display("%0t: unexpected result nsdf=%0d r=%0d m=%0d z=%0b", $time,
                 nsdf_value_o, autocorr_o, energy_o, zero_energy_o);
        errors++;
      end else begin
        lag_result_t exp_r;
        exp_r = lag_results.pop_front();
        if (nsdf_value_o !== exp_r.nsdf) begin
          $display("%0t: nsdf_value expected %0d actual %0d", $time, exp_r.nsdf,
                   nsdf_value_o);
          errors++;
        end
        if (autocorr_o !== exp_r.acorr) begin
          $display("%0t: autocorr expected %0d actual %0d", $time, exp_r.acorr,
                   autocorr_o);
          errors++;
        end
        if (energy_o !== exp_r.energy) begin
          $display("%0t: energy expected %0d actual %0d", $time, exp_r.energy,
                   energy_o);
          errors++;
        end
        if (zero_energy_o !== exp_r.zflag) begin
          $display("%0t: zero_energy expected %0b actual %0b", $time, exp_r.zflag,
                   zero_energy_o);
          errors++;
        end
      end
    end
  end

  function automatic item_t load_cmd(input logic signed [SampleW-1:0] s);
    return '{command: CMD_LOAD, sample: s, lag: '0};
  endfunction

  function automatic item_t query_cmd(input logic [LagW-1:0] t);
    return '{command: CMD_QUERY, sample: SampleW'($urandom), lag: t};
  endfunction

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return SampleW'($urandom_range(0, 40)) - 16'sd20;
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic logic [LagW-1:0] rand_lag();
    case ($urandom_range(0, 3))
      0:       return LagW'($urandom_range(0, 16));
      1:       return LagW'($urandom_range(1000, 1023));
      default: return LagW'($urandom);
    endcase
  endfunction

  // stimulus and end of run
  initial begin
    int n_items;
    // empty store: zero energy at both lag extremes
    cmd_queue.push_back(query_cmd(10'd0));
    cmd_queue.push_back(query_cmd(10'd1023));
    // full-scale negative run: largest products at lag 0
    for (int i = 0; i < 16; i++) cmd_queue.push_back(load_cmd(16'sh8000));
    cmd_queue.push_back(query_cmd(10'd0));
    cmd_queue.push_back(query_cmd(10'd1023));
    cmd_queue.push_back(query_cmd(10'd512));
    // alternating signs after the negative run: negative products at odd lags
    for (int i = 0; i < 8; i++) cmd_queue.push_back(load_cmd(i[0] ? 16'sh7fff : 16'sh8000));
    cmd_queue.push_back(query_cmd(10'd1));
    cmd_queue.push_back(query_cmd(10'd2));
    cmd_queue.push_back(load_cmd(16'sd0));
    cmd_queue.push_back(load_cmd(-16'sd1));
    cmd_queue.push_back(query_cmd(10'd3));
    // random: load bursts followed by queries
    n_items = cmd_queue.size();
    while (n_items < 540) begin
      repeat ($urandom_range(0, 6)) begin
        cmd_queue.push_back(load_cmd(rand_sample()));
        n_items++;
      end
      cmd_queue.push_back(query_cmd(rand_lag()));
      n_items++;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (cmd_queue.size() < 40);
    calm = 1'b1;
    wait (cmd_queue.size() == 0 && !start_i);
    wait (lag_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("[nsdf_pitch_lag_engine_top] OK");
    end else begin
      $display("[nsdf_pitch_lag_engine_top] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 3000000);
    $display("[nsdf_pitch_lag_engine_top] ERROR");
    $finish;
  end

endmodule
